// ===== rtl/core/mre_pkg.sv =====
// ============================================================================
// mre_pkg
// Shared types and constants of the mask run extractor.
// ============================================================================
package mre_pkg;

    localparam int unsigned ColW   = 12;
    localparam int unsigned DimW   = 13;
    localparam int unsigned CountW = 24;

    localparam logic [9:0]        WhiteSum = 10'd765;
    localparam logic [DimW-1:0]   BoxEmpty = 13'd5000;
    localparam logic [CountW-1:0] CountMax = 24'd8388608;
    localparam logic [DimW-1:0]   WidthRst  = 13'd640;
    localparam logic [DimW-1:0]   HeightRst = 13'd480;

    // Register index on the configuration port.
    localparam logic RegWidth  = 1'b0;
    localparam logic RegHeight = 1'b1;

    localparam int unsigned QueueDepth = 2;
    localparam int unsigned QueuePtrW  = 1;
    localparam int unsigned QueueCntW  = 2;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel;

    // Classified pixel, passed from the front part to the back part.
    typedef struct packed {
        logic            clear_pixel;
        logic            run_valid;
        logic [ColW-1:0] run_left;
        logic [DimW-1:0] run_right;
        logic [ColW-1:0] run_row;
        logic            frame_last;
    } t_cls;

    typedef struct packed {
        logic              clear_pixel;
        logic              run_valid;
        logic [ColW-1:0]   run_left;
        logic [DimW-1:0]   run_right;
        logic [ColW-1:0]   run_row;
        logic              frame_last;
        logic [CountW-1:0] run_total;
        logic [DimW-1:0]   box_left;
        logic [DimW-1:0]   box_top;
        logic [DimW-1:0]   box_right;
        logic [DimW-1:0]   box_bottom;
    } t_result;

endpackage

// ===== rtl/core/mre_front.sv =====
// ============================================================================
// mre_front
// Accepts pixels, tracks position and the open run, and classifies each pixel.
// ============================================================================
module mre_front
    import mre_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [DimW-1:0] i_width,
    input  logic [DimW-1:0] i_height,
    input  logic            i_valid,
    input  t_pixel          i_pixel,
    input  logic            i_full,
    output logic            o_push,
    output t_cls            o_item
);

    logic [ColW-1:0] r_column, n_column;
    logic [ColW-1:0] r_row, n_row;
    logic            r_in_run, n_in_run;
    logic [ColW-1:0] r_run_start, n_run_start;

    logic [9:0]      sum;
    logic            clear;
    logic            row_end;
    logic            frame_end;
    logic [DimW-1:0] col_ext;

    assign o_push  = i_valid && !i_full;
    assign sum     = {2'b00, i_pixel.red} + {2'b00, i_pixel.green} + {2'b00, i_pixel.blue};
    assign clear   = (sum == WhiteSum);
    assign col_ext = {1'b0, r_column};
    assign row_end = (col_ext >= (i_width - 13'd1));
    assign frame_end = row_end && ({1'b0, r_row} >= (i_height - 13'd1));

    always_comb begin
        o_item             = '0;
        o_item.clear_pixel = clear;
        o_item.frame_last  = frame_end;
        n_run_start        = r_run_start;
        n_in_run           = r_in_run;
        n_column           = r_column + 12'd1;
        n_row              = r_row;

        if (clear) begin
            if (r_in_run) begin
                o_item.run_valid = 1'b1;
                o_item.run_left  = r_run_start;
                o_item.run_right = col_ext;
            end
            n_in_run = 1'b0;
        end else begin
            if (!r_in_run) begin
                n_run_start = r_column;
            end
            n_in_run = 1'b1;
            if (row_end) begin
                o_item.run_valid = 1'b1;
                o_item.run_left  = r_in_run ? r_run_start : r_column;
                o_item.run_right = col_ext + 13'd1;
                n_in_run         = 1'b0;
            end
        end
        if (o_item.run_valid) begin
            o_item.run_row = r_row;
        end

        if (frame_end) begin
            n_column    = '0;
            n_row       = '0;
            n_in_run    = 1'b0;
            n_run_start = '0;
        end else if (row_end) begin
            n_column = '0;
            n_in_run = 1'b0;
            n_row    = r_row + 12'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column    <= '0;
            r_row       <= '0;
            r_in_run    <= 1'b0;
            r_run_start <= '0;
        end else if (o_push) begin
            r_column    <= n_column;
            r_row       <= n_row;
            r_in_run    <= n_in_run;
            r_run_start <= n_run_start;
        end
    end

`ifndef SYNTH
    a_run_start_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_run |-> (r_run_start <= r_column))
        else $error("open run starts past the current column");
    a_no_open_run_at_row_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_column == '0) |-> !r_in_run)
        else $error("run left open across a row boundary");
`endif

endmodule

// ===== rtl/core/mre_queue.sv =====
// ============================================================================
// mre_queue
// Short queue that decouples the classifying front from the summary back.
// ============================================================================
module mre_queue
    import mre_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cls i_data,
    input  logic i_pop,
    output t_cls o_data,
    output logic o_full,
    output logic o_empty
);

    t_cls                 r_mem [QueueDepth];
    logic [QueuePtrW-1:0] r_wr_ptr;
    logic [QueuePtrW-1:0] r_rd_ptr;
    logic [QueueCntW-1:0] r_count, n_count;

    assign o_full  = (r_count == QueueCntW'(QueueDepth));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 2'd1;
            2'b01:   n_count = r_count - 2'd1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into a full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("pop from an empty queue");
`endif

endmodule

// ===== rtl/core/mre_back.sv =====
// ============================================================================
// mre_back
// Keeps the per-frame run count and bounding box and holds the result register.
// ============================================================================
module mre_back
    import mre_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_empty,
    input  t_cls    i_item,
    output logic    o_pop,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_result
);

    logic [CountW-1:0] r_total, n_total;
    logic [DimW-1:0]   r_left, n_left;
    logic [DimW-1:0]   r_top, n_top;
    logic [DimW-1:0]   r_right, n_right;
    logic [DimW-1:0]   r_bottom, n_bottom;
    logic              r_out_valid;
    t_result           r_out, n_out;
    logic [DimW-1:0]   row_ext;

    assign o_pop    = !i_empty && (!r_out_valid || !i_stall);
    assign o_valid  = r_out_valid;
    assign o_result = r_out;
    assign row_ext  = {1'b0, i_item.run_row};

    always_comb begin
        n_total  = r_total;
        n_left   = r_left;
        n_top    = r_top;
        n_right  = r_right;
        n_bottom = r_bottom;
        if (i_item.run_valid) begin
            if (r_total < CountMax) begin
                n_total = r_total + 24'd1;
            end
            if ({1'b0, i_item.run_left} < r_left) begin
                n_left = {1'b0, i_item.run_left};
            end
            if (i_item.run_right > r_right) begin
                n_right = i_item.run_right;
            end
            if (row_ext < r_top) begin
                n_top = row_ext;
            end
            if ((row_ext + 13'd1) > r_bottom) begin
                n_bottom = row_ext + 13'd1;
            end
        end

        n_out.clear_pixel = i_item.clear_pixel;
        n_out.run_valid   = i_item.run_valid;
        n_out.run_left    = i_item.run_left;
        n_out.run_right   = i_item.run_right;
        n_out.run_row     = i_item.run_row;
        n_out.frame_last  = i_item.frame_last;
        n_out.run_total   = n_total;
        n_out.box_left    = n_left;
        n_out.box_top     = n_top;
        n_out.box_right   = n_right;
        n_out.box_bottom  = n_bottom;
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_total     <= '0;
            r_left      <= BoxEmpty;
            r_top       <= BoxEmpty;
            r_right     <= '0;
            r_bottom    <= '0;
        end else begin
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop) begin
                // The summary starts over once the frame's last pixel is out.
                if (i_item.frame_last) begin
                    r_total  <= '0;
                    r_left   <= BoxEmpty;
                    r_top    <= BoxEmpty;
                    r_right  <= '0;
                    r_bottom <= '0;
                end else begin
                    r_total  <= n_total;
                    r_left   <= n_left;
                    r_top    <= n_top;
                    r_right  <= n_right;
                    r_bottom <= n_bottom;
                end
            end
        end
    end

`ifndef SYNTH
    a_count_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= CountMax)
        else $error("run count beyond its saturation value");
    a_box_tracks_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_total == '0) == (r_bottom == '0))
        else $error("bounding box disagrees with the run count");
`endif

endmodule

// ===== rtl/core/mask_run_extractor_top.sv =====
// ============================================================================
// mask_run_extractor_top
// White-keyed opaque run extraction over a raster RGB pixel stream.
// ============================================================================
// Pixels enter in raster order on the input channel (i_in_valid, o_in_stall,
// i_in_data); a transfer happens when valid is high and stall is low. Each
// pixel gives exactly one result on the output channel (o_out_valid,
// i_out_stall, o_out_data) with the transparency flag, the opaque run that
// closes on it, if any, and the frame's running run count and bounding box.
// The front classifies a pixel in the cycle it is taken and writes it into a
// two-entry queue; the back pops it, updates the summary and loads the result
// register. One pixel per cycle is sustained while the receiver does not
// stall, limited by the single summary update per cycle in the back. When the
// receiver stalls, the result register holds and the queue absorbs up to two
// more pixels before o_in_stall rises. Reset clears position, run state,
// summary and queue, and loads the width and height registers with 640 and
// 480. The summary is final on the result flagged frame_last and starts over
// with the next pixel. Width and height are written over APB at byte addresses
// 0 and 4; the user must do so only while idle, as the block does not check.
// ============================================================================
module mask_run_extractor_top
    import mre_pkg::*;
#(
    parameter int MAX_DIMENSION = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_pixel      i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_result     o_out_data
);

    localparam logic [DimW-1:0] MaxDim = DimW'(MAX_DIMENSION);

    logic [DimW-1:0] r_width;
    logic [DimW-1:0] r_height;
    logic [DimW-1:0] width_eff;
    logic [DimW-1:0] height_eff;
    logic            cfg_write;
    logic            push;
    logic            pop;
    logic            full;
    logic            empty;
    t_cls            push_item;
    t_cls            pop_item;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == RegHeight) ? {19'd0, r_height} : {19'd0, r_width};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WidthRst;
            r_height <= HeightRst;
        end else if (cfg_write) begin
            if (paddr[2] == RegWidth) begin
                r_width <= pwdata[DimW-1:0];
            end else begin
                r_height <= pwdata[DimW-1:0];
            end
        end
    end

    // Zero acts as one, and anything above the maximum acts as the maximum.
    always_comb begin
        width_eff = r_width;
        if (r_width == '0) begin
            width_eff = 13'd1;
        end else if (r_width > MaxDim) begin
            width_eff = MaxDim;
        end
        height_eff = r_height;
        if (r_height == '0) begin
            height_eff = 13'd1;
        end else if (r_height > MaxDim) begin
            height_eff = MaxDim;
        end
    end

    assign o_in_stall = full;

    mre_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_width  (width_eff),
        .i_height (height_eff),
        .i_valid  (i_in_valid),
        .i_pixel  (i_in_data),
        .i_full   (full),
        .o_push   (push),
        .o_item   (push_item)
    );

    mre_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_item),
        .i_pop   (pop),
        .o_data  (pop_item),
        .o_full  (full),
        .o_empty (empty)
    );

    mre_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (empty),
        .i_item   (pop_item),
        .o_pop    (pop),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_result (o_out_data)
    );

endmodule
